FILE: hdl/dtre_pkg.sv
package dtre_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 32;
   localparam int SLOT_W = 5;
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 32;

   localparam logic CMD_OBSERVE = 1'b0;
   localparam logic CMD_LOOKUP  = 1'b1;

   localparam logic [2:0] STS_UPDATED  = 3'd0;
   localparam logic [2:0] STS_INSERTED = 3'd1;
   localparam logic [2:0] STS_EVICTED  = 3'd2;
   localparam logic [2:0] STS_DROPPED  = 3'd3;
   localparam logic [2:0] STS_HIT      = 3'd4;
   localparam logic [2:0] STS_MISS     = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic               vld;
      logic               cmd;
      logic [47:0]        addr;
      logic signed [7:0]  sig;
      logic               has_name;
      logic               is_clim;
      logic               has_data;
      logic signed [15:0] temp;
      logic [7:0]         hum;
      logic               found;
      logic               free_found;
      logic               weak_found;
      logic signed [7:0]  weak_sig;
      logic signed [15:0] hit_temp;
      logic [7:0]         hit_hum;
   } probe_type;

   typedef struct packed {
      logic               en;
      logic               fresh;
      logic [47:0]        addr;
      logic signed [7:0]  sig;
      logic               has_name;
      logic               is_clim;
      logic               has_data;
      logic signed [15:0] temp;
      logic [7:0]         hum;
   } wr_type;

endpackage

FILE: hdl/dtre_cell.sv
module dtre_cell #(
   parameter int IDX = 0,
   parameter int IW  = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dtre_pkg::probe_type  up_probe,
   input  logic [IW-1:0]        up_found_idx,
   input  logic [IW-1:0]        up_free_idx,
   input  logic [IW-1:0]        up_weak_idx,
   output dtre_pkg::probe_type  dn_probe,
   output logic [IW-1:0]        dn_found_idx,
   output logic [IW-1:0]        dn_free_idx,
   output logic [IW-1:0]        dn_weak_idx,
   input  dtre_pkg::wr_type     wr,
   input  logic [IW-1:0]        wr_idx
);

   localparam logic [IW-1:0] MY_IDX = IW'(IDX);

   logic               valid_ff, valid_in;
   logic [47:0]        addr_ff, addr_in;
   logic signed [7:0]  sig_ff, sig_in;
   logic               climate_ff, climate_in;
   logic signed [15:0] temp_ff, temp_in;
   logic [7:0]         hum_ff, hum_in;

   dtre_pkg::probe_type probe_ff, probe_in;
   logic [IW-1:0]       found_idx_ff, found_idx_in;
   logic [IW-1:0]       free_idx_ff, free_idx_in;
   logic [IW-1:0]       weak_idx_ff, weak_idx_in;

   logic addr_hit;
   logic wr_hit;

   assign addr_hit = valid_ff && (addr_ff == up_probe.addr);
   assign wr_hit   = wr.en && (wr_idx == MY_IDX);

   // entry update
   always_comb begin
      valid_in   = valid_ff;
      addr_in    = addr_ff;
      sig_in     = sig_ff;
      climate_in = climate_ff;
      temp_in    = temp_ff;
      hum_in     = hum_ff;
      if (wr_hit) begin
         valid_in = 1'b1;
         addr_in  = wr.addr;
         sig_in   = wr.sig;
         if (wr.has_name) begin
            climate_in = wr.is_clim;
         end else if (wr.fresh) begin
            climate_in = 1'b0;
         end
         if (wr.has_data) begin
            temp_in = wr.temp;
            hum_in  = wr.hum;
         end else if (wr.fresh) begin
            temp_in = '0;
            hum_in  = '0;
         end
      end
   end

   // probe stage
   always_comb begin
      probe_in     = up_probe;
      found_idx_in = up_found_idx;
      free_idx_in  = up_free_idx;
      weak_idx_in  = up_weak_idx;
      if (up_probe.vld && !up_probe.found) begin
         if (up_probe.cmd == dtre_pkg::CMD_LOOKUP) begin
            if (addr_hit && climate_ff) begin
               probe_in.found    = 1'b1;
               probe_in.hit_temp = temp_ff;
               probe_in.hit_hum  = hum_ff;
               found_idx_in      = MY_IDX;
            end
         end else begin
            if (addr_hit) begin
               probe_in.found = 1'b1;
               found_idx_in   = MY_IDX;
            end else begin
               if (!valid_ff && !up_probe.free_found) begin
                  probe_in.free_found = 1'b1;
                  free_idx_in         = MY_IDX;
               end
               if (valid_ff && (!up_probe.weak_found || sig_ff < up_probe.weak_sig)) begin
                  probe_in.weak_found = 1'b1;
                  probe_in.weak_sig   = sig_ff;
                  weak_idx_in         = MY_IDX;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         probe_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         probe_ff <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      sig_ff       <= sig_in;
      climate_ff   <= climate_in;
      temp_ff      <= temp_in;
      hum_ff       <= hum_in;
      found_idx_ff <= found_idx_in;
      free_idx_ff  <= free_idx_in;
      weak_idx_ff  <= weak_idx_in;
   end

   assign dn_probe     = probe_ff;
   assign dn_found_idx = found_idx_ff;
   assign dn_free_idx  = free_idx_ff;
   assign dn_weak_idx  = weak_idx_ff;

endmodule

FILE: hdl/dtre_ctrl.sv
module dtre_ctrl #(
   parameter int IW = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_cmd,
   input  logic [47:0]          req_addr,
   input  logic signed [7:0]    req_sig,
   input  logic                 req_has_name,
   input  logic                 req_is_clim,
   input  logic                 req_has_data,
   input  logic signed [15:0]   req_temp,
   input  logic [7:0]           req_hum,
   output dtre_pkg::probe_type  head_probe,
   input  dtre_pkg::probe_type  tail_probe,
   input  logic [IW-1:0]        tail_found_idx,
   input  logic [IW-1:0]        tail_free_idx,
   input  logic [IW-1:0]        tail_weak_idx,
   output dtre_pkg::wr_type     wr,
   output logic [IW-1:0]        wr_idx,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [2:0]           rsp_status,
   output logic [dtre_pkg::SLOT_W-1:0] rsp_slot,
   output logic signed [15:0]   rsp_temp,
   output logic [7:0]           rsp_hum
);

   dtre_pkg::state_type state_ff, state_in;

   dtre_pkg::probe_type hold_ff, hold_in;
   logic [IW-1:0]       found_idx_ff, found_idx_in;
   logic [IW-1:0]       free_idx_ff, free_idx_in;
   logic [IW-1:0]       weak_idx_ff, weak_idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic [dtre_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic signed [15:0]  rsp_temp_ff, rsp_temp_in;
   logic [7:0]          rsp_hum_ff, rsp_hum_in;

   logic                out_free;
   logic                commit;
   logic [IW-1:0]       sel_idx;
   logic [IW+dtre_pkg::SLOT_W-1:0] sel_idx_ext;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign commit      = (state_ff == dtre_pkg::ST_COMMIT) && out_free;
   assign req_tready  = (state_ff == dtre_pkg::ST_IDLE);
   assign sel_idx_ext = {{dtre_pkg::SLOT_W{1'b0}}, sel_idx};

   always_comb begin
      head_probe            = '0;
      head_probe.vld        = req_tvalid && req_tready;
      head_probe.cmd        = req_cmd;
      head_probe.addr       = req_addr;
      head_probe.sig        = req_sig;
      head_probe.has_name   = req_has_name;
      head_probe.is_clim    = req_is_clim;
      head_probe.has_data   = req_has_data;
      head_probe.temp       = req_temp;
      head_probe.hum        = req_hum;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtre_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = dtre_pkg::ST_SCAN;
            end
         end
         dtre_pkg::ST_SCAN: begin
            if (tail_probe.vld) begin
               state_in = dtre_pkg::ST_COMMIT;
            end
         end
         dtre_pkg::ST_COMMIT: begin
            if (out_free) begin
               state_in = dtre_pkg::ST_IDLE;
            end
         end
         default: state_in = dtre_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      hold_in       = hold_ff;
      found_idx_in  = found_idx_ff;
      free_idx_in   = free_idx_ff;
      weak_idx_in   = weak_idx_ff;
      if (state_ff == dtre_pkg::ST_SCAN && tail_probe.vld) begin
         hold_in      = tail_probe;
         found_idx_in = tail_found_idx;
         free_idx_in  = tail_free_idx;
         weak_idx_in  = tail_weak_idx;
      end

      wr.en       = 1'b0;
      wr.fresh    = 1'b0;
      wr.addr     = hold_ff.addr;
      wr.sig      = hold_ff.sig;
      wr.has_name = hold_ff.has_name;
      wr.is_clim  = hold_ff.is_clim;
      wr.has_data = hold_ff.has_data;
      wr.temp     = hold_ff.temp;
      wr.hum      = hold_ff.hum;
      sel_idx     = found_idx_ff;
      rsp_status_in = dtre_pkg::STS_DROPPED;
      rsp_temp_in   = '0;
      rsp_hum_in    = '0;

      if (hold_ff.cmd == dtre_pkg::CMD_LOOKUP) begin
         if (hold_ff.found) begin
            rsp_status_in = dtre_pkg::STS_HIT;
            rsp_temp_in   = hold_ff.hit_temp;
            rsp_hum_in    = hold_ff.hit_hum;
         end else begin
            rsp_status_in = dtre_pkg::STS_MISS;
            sel_idx       = '0;
         end
      end else if (hold_ff.found) begin
         rsp_status_in = dtre_pkg::STS_UPDATED;
         wr.en         = commit;
      end else if (hold_ff.free_found) begin
         rsp_status_in = dtre_pkg::STS_INSERTED;
         sel_idx       = free_idx_ff;
         wr.en         = commit;
         wr.fresh      = 1'b1;
      end else if (hold_ff.weak_found && hold_ff.sig > hold_ff.weak_sig) begin
         rsp_status_in = dtre_pkg::STS_EVICTED;
         sel_idx       = weak_idx_ff;
         wr.en         = commit;
         wr.fresh      = 1'b1;
      end else begin
         sel_idx = '0;
      end
      wr_idx      = sel_idx;
      rsp_slot_in = sel_idx_ext[dtre_pkg::SLOT_W-1:0];

      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtre_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff      <= hold_in;
      found_idx_ff <= found_idx_in;
      free_idx_ff  <= free_idx_in;
      weak_idx_ff  <= weak_idx_in;
      if (commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_temp_ff   <= rsp_temp_in;
         rsp_hum_ff    <= rsp_hum_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_temp   = rsp_temp_ff;
   assign rsp_hum    = rsp_hum_ff;

`ifndef SYNTHESIS
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == dtre_pkg::ST_SCAN))
      else $error("accepted transaction did not start a scan");

   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail_probe.vld |-> (state_ff == dtre_pkg::ST_SCAN))
      else $error("probe left the chain outside a scan");

   a_write_on_commit: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (commit && hold_ff.cmd == dtre_pkg::CMD_OBSERVE))
      else $error("table write outside an observe commit");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == dtre_pkg::ST_COMMIT))
      else $error("response raised without a commit");
`endif

endmodule

FILE: hdl/device_table_rssi_evict_unit.sv
// One transaction is in flight at a time: a new request is accepted only in
// the idle state, after the previous one has been scanned and committed. The
// probe walks the chain of table cells, one cell per cycle.
// A finished response waits in the output register while the next request
// is scanned. Reset (synchronous, active high) clears all entry valid bits
// and control state; no clearing pass is needed.
module device_table_rssi_evict_unit #(
   parameter int TABLE_DEPTH = dtre_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // dev_addr[47:0], signal_level[55:48], has_name[56], name_is_climate[57],
   // has_sensor_data[58], temp_tenths[74:59], humidity_in[82:75], zero pad
   input  logic [dtre_pkg::REQ_TDATA_W-1:0] req_tdata,
   // cmd[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], slot_used[7:3], temp_out[23:8], humidity_out[31:24]
   output logic [dtre_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   dtre_pkg::probe_type probe_chain [0:TABLE_DEPTH];
   logic [IW-1:0]       found_chain [0:TABLE_DEPTH];
   logic [IW-1:0]       free_chain  [0:TABLE_DEPTH];
   logic [IW-1:0]       weak_chain  [0:TABLE_DEPTH];

   dtre_pkg::wr_type    wr;
   logic [IW-1:0]       wr_idx;

   logic [2:0]          rsp_status;
   logic [dtre_pkg::SLOT_W-1:0] rsp_slot;
   logic signed [15:0]  rsp_temp;
   logic [7:0]          rsp_hum;

   assign found_chain[0] = '0;
   assign free_chain[0]  = '0;
   assign weak_chain[0]  = '0;

   dtre_ctrl #(
      .IW(IW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_cmd        (req_tuser),
      .req_addr       (req_tdata[47:0]),
      .req_sig        (req_tdata[55:48]),
      .req_has_name   (req_tdata[56]),
      .req_is_clim    (req_tdata[57]),
      .req_has_data   (req_tdata[58]),
      .req_temp       (req_tdata[74:59]),
      .req_hum        (req_tdata[82:75]),
      .head_probe     (probe_chain[0]),
      .tail_probe     (probe_chain[TABLE_DEPTH]),
      .tail_found_idx (found_chain[TABLE_DEPTH]),
      .tail_free_idx  (free_chain[TABLE_DEPTH]),
      .tail_weak_idx  (weak_chain[TABLE_DEPTH]),
      .wr             (wr),
      .wr_idx         (wr_idx),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot),
      .rsp_temp       (rsp_temp),
      .rsp_hum        (rsp_hum)
   );

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      dtre_cell #(
         .IDX (i),
         .IW  (IW)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .up_probe     (probe_chain[i]),
         .up_found_idx (found_chain[i]),
         .up_free_idx  (free_chain[i]),
         .up_weak_idx  (weak_chain[i]),
         .dn_probe     (probe_chain[i+1]),
         .dn_found_idx (found_chain[i+1]),
         .dn_free_idx  (free_chain[i+1]),
         .dn_weak_idx  (weak_chain[i+1]),
         .wr           (wr),
         .wr_idx       (wr_idx)
      );
   end

   assign rsp_tdata = {rsp_hum, rsp_temp, rsp_slot, rsp_status};

endmodule
